[hdl/mtf_pkg.sv]
// Shared types and constants for the max-tracking FIFO.
// Holds the cell state, per-cell control and the op and status codes.
// No dependencies.
package mtf_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VAL_W     = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] maximum;
    } cell_t;

    typedef struct packed {
        logic                    push;
        logic                    pop;
        logic signed [VAL_W-1:0] value;
    } cell_ctrl_t;

endpackage

[hdl/mtf_cell.sv]
// One queue slot: holds a value and the maximum of it and all later entries.
// Shifts toward the front on pop, loads or raises its maximum on push.
// Depends on mtf_pkg.
module mtf_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  mtf_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,  // slot nearer the front is occupied
    input  mtf_pkg::cell_t      upper,       // slot nearer the back
    output mtf_pkg::cell_t      state,
    output mtf_pkg::cell_t      state_next
);

    logic                            valid_reg;
    logic signed [mtf_pkg::VAL_W-1:0] value_reg;
    logic signed [mtf_pkg::VAL_W-1:0] maximum_reg;

    assign state.valid   = valid_reg;
    assign state.value   = value_reg;
    assign state.maximum = maximum_reg;

    always_comb
    begin
        state_next = state;
        if (ctrl.pop)
        begin
            state_next = upper;
        end
        else if (ctrl.push)
        begin
            if (valid_reg)
            begin
                if (maximum_reg < ctrl.value)
                begin
                    state_next.maximum = ctrl.value;
                end
            end
            else if (prev_valid)
            begin
                // first free slot takes the new tail
                state_next.valid   = 1'b1;
                state_next.value   = ctrl.value;
                state_next.maximum = ctrl.value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= state_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= state_next.value;
        maximum_reg <= state_next.maximum;
    end

endmodule

[hdl/max_tracking_fifo.sv]
// Max-tracking FIFO top level: a row of mtf_cell slots, front at slot 0.
// Depends on mtf_pkg and mtf_cell.
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  s_*     | in  | tuser: op; tdata: value
//  m_*     | out | tdata: front_value, front_maximum, entry_count;
//          |     | tuser: is_empty, status
//
// One beat per cycle unless a result stalls; the result is registered and appears the cycle after
// acceptance. All slots compare and update their maxima in parallel, and a
// pop shifts every slot one place toward the front in the same cycle.
// Reset empties the queue (valid and count registers only). A stalled result holds the
// output register; s_tready drops only while that result is still unread.
module max_tracking_fifo
#(
    parameter int unsigned DEPTH = mtf_pkg::DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [mtf_pkg::VAL_W-1:0]   s_tdata,   // [31:0] value
    input  logic [0:0]                  s_tuser,   // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [((2*mtf_pkg::VAL_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
        // [31:0] front_value, [63:32] front_maximum, then entry_count
    output logic [2:0]                  m_tuser    // [0] is_empty, [2:1] status
);

    localparam int unsigned CNT_W   = $clog2(DEPTH+1);
    localparam int unsigned TDATA_W = ((2*mtf_pkg::VAL_W+CNT_W+7)/8)*8;

    mtf_pkg::cell_t      cur   [DEPTH];
    mtf_pkg::cell_t      nxt   [DEPTH];
    mtf_pkg::cell_t      upper [DEPTH];
    logic [DEPTH-1:0]    prev_v;
    logic [DEPTH-1:0]    valids;
    mtf_pkg::cell_ctrl_t ctrl;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    logic signed [mtf_pkg::VAL_W-1:0] out_value_reg, out_max_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_empty_reg;
    logic [1:0]       out_status_reg;

    logic       in_fire, full, empty, push_ok, pop_ok;
    logic [1:0] status;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign full     = cur[DEPTH-1].valid;
    assign empty    = !cur[0].valid;
    assign push_ok  = in_fire && (s_tuser[0] == mtf_pkg::OP_PUSH) && !full;
    assign pop_ok   = in_fire && (s_tuser[0] == mtf_pkg::OP_POP) && !empty;

    assign ctrl.push  = push_ok;
    assign ctrl.pop   = pop_ok;
    assign ctrl.value = s_tdata;

    always_comb
    begin
        status = mtf_pkg::ST_OK;
        if (s_tuser[0] == mtf_pkg::OP_PUSH)
        begin
            if (full)
            begin
                status = mtf_pkg::ST_FULL;
            end
        end
        else if (empty)
        begin
            status = mtf_pkg::ST_EMPTY;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == DEPTH-1)
        begin : g_last
            assign upper[i] = '0;
        end
        else
        begin : g_mid
            assign upper[i] = cur[i+1];
        end
        if (i == 0)
        begin : g_front
            assign prev_v[i] = 1'b1;
        end
        else
        begin : g_rest
            assign prev_v[i] = cur[i-1].valid;
        end
        assign valids[i] = cur[i].valid;

        mtf_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_valid (prev_v[i]),
            .upper      (upper[i]),
            .state      (cur[i]),
            .state_next (nxt[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_value_reg  <= nxt[0].valid ? nxt[0].value : '0;
            out_max_reg    <= nxt[0].valid ? nxt[0].maximum : '0;
            out_count_reg  <= count_next;
            out_empty_reg  <= (count_next == '0);
            out_status_reg <= status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_count_reg, out_max_reg, out_value_reg});
    assign m_tuser  = {out_status_reg, out_empty_reg};

    // occupancy count agrees with the slot valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valids) == count_reg)
        else $error("count differs from occupied slots");

    // occupied slots form a run starting at the front
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valids} + {{DEPTH{1'b0}}, 1'b1}))
        else $error("occupied slots not contiguous");

    // front maximum never below front value
    a_front_max: assert property (@(posedge clk) disable iff (!rst_n)
        cur[0].valid |-> (cur[0].maximum >= cur[0].value))
        else $error("front maximum below front value");

    // a full rejection reports a full queue
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (out_status_reg == mtf_pkg::ST_FULL)) |->
            (out_count_reg == CNT_W'(DEPTH)))
        else $error("full status with queue not full");

endmodule

[verif/tb_max_tracking_fifo.sv]
// Self-checking testbench for max_tracking_fifo: directed and random push/pop beats
// are checked against a shadow queue that tracks each entry's suffix maximum.
// Depends on mtf_pkg and the max_tracking_fifo RTL.
module tb_max_tracking_fifo;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH     = mtf_pkg::DEPTH_DEF;
    localparam int unsigned VAL_W     = mtf_pkg::VAL_W;
    localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
    localparam int unsigned TDATA_W   = ((2 * VAL_W + CNT_W + 7) / 8) * 8;
    localparam int unsigned CYC_LIMIT = 200000;
    localparam int unsigned MAX_PRINT = 40;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] maximum;
    } slot_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] front_maximum;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_empty;
        logic [1:0]              status;
    } fifo_result_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VAL_W-1:0]   s_tdata  = '0;   // [31:0] value
    logic [0:0]         s_tuser  = mtf_pkg::OP_PUSH;   // [0] op
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;   // [31:0] front_value, [63:32] front_maximum, entry_count
    logic [2:0]         m_tuser;   // [0] is_empty, [2:1] status

    slot_t        shadow_q[$];
    fifo_result_t pending_results[$];

    int unsigned err_count     = 0;
    int unsigned beat_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_cycles  = 0;

    max_tracking_fifo #(.DEPTH(DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow queue: a push raises the kept maximum of every older entry.
    function automatic fifo_result_t fifo_apply(logic op,
                                                logic signed [VAL_W-1:0] val);
        fifo_result_t res;
        res.status = mtf_pkg::ST_OK;
        if (op == mtf_pkg::OP_PUSH)
        begin
            if (shadow_q.size() >= DEPTH)
                res.status = mtf_pkg::ST_FULL;
            else
            begin
                foreach (shadow_q[i])
                    if (shadow_q[i].maximum < val)
                        shadow_q[i].maximum = val;
                shadow_q.push_back('{value: val, maximum: val});
            end
        end
        else
        begin
            if (shadow_q.size() == 0)
                res.status = mtf_pkg::ST_EMPTY;
            else
                void'(shadow_q.pop_front());
        end
        res.entry_count = CNT_W'(shadow_q.size());
        res.is_empty    = (shadow_q.size() == 0);
        if (res.is_empty)
        begin
            res.front_value   = '0;
            res.front_maximum = '0;
        end
        else
        begin
            res.front_value   = shadow_q[0].value;
            res.front_maximum = shadow_q[0].maximum;
        end
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [VAL_W-1:0] got, logic [VAL_W-1:0] exp);
        if (err_count < MAX_PRINT)
            $display("ERROR %0t: result beat %0d %s got %h exp %h",
                     $time, beat_count, field, got, exp);
        err_count++;
    endtask

    // Output check first, then predict the input beat accepted at this edge.
    always @(posedge clk)
    begin
        fifo_result_t exp_res;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", m_tdata[VAL_W-1:0], '0);
            else
            begin
                exp_res = pending_results.pop_front();
                if (m_tdata[VAL_W-1:0] !== exp_res.front_value)
                    report_mismatch("front_value", m_tdata[VAL_W-1:0], exp_res.front_value);
                if (m_tdata[VAL_W +: VAL_W] !== exp_res.front_maximum)
                    report_mismatch("front_maximum", m_tdata[VAL_W +: VAL_W],
                                    exp_res.front_maximum);
                if (m_tdata[2*VAL_W +: CNT_W] !== exp_res.entry_count)
                    report_mismatch("entry_count", VAL_W'(m_tdata[2*VAL_W +: CNT_W]),
                                    VAL_W'(exp_res.entry_count));
                if (m_tuser[0] !== exp_res.is_empty)
                    report_mismatch("is_empty", VAL_W'(m_tuser[0]),
                                    VAL_W'(exp_res.is_empty));
                if (m_tuser[2:1] !== exp_res.status)
                    report_mismatch("status", VAL_W'(m_tuser[2:1]),
                                    VAL_W'(exp_res.status));
            end
            beat_count++;
        end
        if (s_tvalid && s_tready)
            pending_results.push_back(fifo_apply(s_tuser[0], s_tdata));
    end

    // Receiver: random idling, or a long hold-off when stall_cycles is loaded.
    always @(negedge clk)
    begin
        if (stall_cycles > 0)
        begin
            m_tready <= 1'b0;
            stall_cycles <= stall_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("max_tracking_fifo: mismatch");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid stays up for a following beat.
    task automatic send_beat(logic op, logic [VAL_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= val;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_pacing(int unsigned snd_pct, int unsigned rcv_pct, int unsigned hold);
        s_tvalid <= 1'b0;
        @(posedge clk);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        stall_cycles  = hold;
        @(negedge clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2, 3:    return $unsigned($signed($urandom_range(0, 8)) - 4);
            default: return $urandom;
        endcase
    endfunction

    // Pop on empty, extremes of the value range, value ignored on pop.
    task automatic test_special_cases();
        send_beat(mtf_pkg::OP_POP,  32'h0000_0000);
        send_beat(mtf_pkg::OP_PUSH, 32'h8000_0000);
        send_beat(mtf_pkg::OP_PUSH, 32'h7fff_ffff);
        send_beat(mtf_pkg::OP_PUSH, 32'hffff_ffff);
        send_beat(mtf_pkg::OP_POP,  32'hffff_ffff);
        send_beat(mtf_pkg::OP_POP,  32'h7fff_ffff);
        send_beat(mtf_pkg::OP_POP,  32'h0000_0000);
        send_beat(mtf_pkg::OP_POP,  32'h7fff_ffff);
        drain_results();
    endtask

    // Fill to depth with mixed values, then push into the full queue.
    task automatic test_fill_to_full();
        for (int i = 0; i < DEPTH; i++)
            send_beat(mtf_pkg::OP_PUSH, (i % 3 == 0) ? $urandom : rand_value());
        send_beat(mtf_pkg::OP_PUSH, 32'h7fff_ffff);
        drain_results();
    endtask

    task automatic test_random_ops(int unsigned n, int unsigned snd_pct, int unsigned rcv_pct);
        int unsigned push_pct;
        int unsigned bias_sel[4] = '{75, 25, 50, 90};
        set_pacing(snd_pct, rcv_pct, 0);
        push_pct = 50;
        for (int i = 0; i < n; i++)
        begin
            // drift in stretches so the queue runs full and empty
            if (i % 40 == 0)
                push_pct = bias_sel[$urandom_range(0, 3)];
            send_beat(($urandom_range(0, 99) < push_pct) ? mtf_pkg::OP_PUSH : mtf_pkg::OP_POP,
                      rand_value());
        end
        drain_results();
    endtask

    // Receiver holds off while the sender keeps offering; input must stall.
    task automatic test_backpressure();
        set_pacing(0, 0, 120);
        for (int i = 0; i < 30; i++)
            send_beat(($urandom_range(0, 99) < 70) ? mtf_pkg::OP_PUSH : mtf_pkg::OP_POP,
                      rand_value());
        drain_results();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_special_cases();
        test_fill_to_full();
        test_random_ops(170, 31, 68);
        test_backpressure();
        test_random_ops(170, 68, 31);
        test_random_ops(170, 0, 0);

        if (err_count == 0)
            $display("max_tracking_fifo: match");
        else
            $display("max_tracking_fifo: mismatch");
        $finish;
    end

endmodule

[files.f]
hdl/mtf_pkg.sv
hdl/mtf_cell.sv
hdl/max_tracking_fifo.sv
verif/tb_max_tracking_fifo.sv
